// File: hdl/gcds_pkg.sv
// Shared types, constants and neighbour tables for the grid cell division block.
// Used by gcds_front, gcds_fifo, gcds_back and grid_cell_division_step.
`timescale 1ns / 1ps
`default_nettype none
package gcds_pkg;

   localparam int ROWS_DEF = 64;
   localparam int COLS_DEF = 64;
   localparam int NB_MAX   = 8;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_DIVIDE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // neighbour directions
   typedef enum logic [2:0] {
      DIR_L  = 3'd0,
      DIR_R  = 3'd1,
      DIR_U  = 3'd2,
      DIR_D  = 3'd3,
      DIR_UL = 3'd4,
      DIR_UR = 3'd5,
      DIR_LD = 3'd6,
      DIR_RD = 3'd7
   } dir_type;

   // position classes of the addressed site
   typedef enum logic [3:0] {
      LOC_TL     = 4'd0,
      LOC_TR     = 4'd1,
      LOC_TOP    = 4'd2,
      LOC_BL     = 4'd3,
      LOC_BR     = 4'd4,
      LOC_BOTTOM = 4'd5,
      LOC_LEFT   = 4'd6,
      LOC_RIGHT  = 4'd7,
      LOC_INNER  = 4'd8
   } loc_type;

   localparam dir_type NB_LIST [9][8] = '{
      '{DIR_R, DIR_RD, DIR_D, DIR_L, DIR_L, DIR_L, DIR_L, DIR_L},
      '{DIR_L, DIR_LD, DIR_D, DIR_L, DIR_L, DIR_L, DIR_L, DIR_L},
      '{DIR_L, DIR_R, DIR_D, DIR_LD, DIR_RD, DIR_L, DIR_L, DIR_L},
      '{DIR_U, DIR_UR, DIR_R, DIR_L, DIR_L, DIR_L, DIR_L, DIR_L},
      '{DIR_L, DIR_U, DIR_UL, DIR_L, DIR_L, DIR_L, DIR_L, DIR_L},
      '{DIR_L, DIR_UL, DIR_U, DIR_UR, DIR_R, DIR_L, DIR_L, DIR_L},
      '{DIR_U, DIR_UR, DIR_R, DIR_RD, DIR_D, DIR_L, DIR_L, DIR_L},
      '{DIR_U, DIR_UL, DIR_L, DIR_LD, DIR_D, DIR_L, DIR_L, DIR_L},
      '{DIR_L, DIR_R, DIR_U, DIR_D, DIR_UL, DIR_UR, DIR_LD, DIR_RD}
   };

   localparam logic [3:0] NB_LEN [9] = '{4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd5, 4'd5, 4'd5, 4'd8};

   function automatic int drow(dir_type d);
      case (d)
         DIR_U, DIR_UL, DIR_UR: drow = -1;
         DIR_D, DIR_LD, DIR_RD: drow = 1;
         default:               drow = 0;
      endcase
   endfunction

   function automatic int dcol(dir_type d);
      case (d)
         DIR_L, DIR_UL, DIR_LD: dcol = -1;
         DIR_R, DIR_UR, DIR_RD: dcol = 1;
         default:               dcol = 0;
      endcase
   endfunction

   // one classified command, queued between front and back
   typedef struct packed {
      cmd_type                     cmd;
      logic                        in_grid;
      logic [5:0]                  row;
      logic [5:0]                  col;
      logic                        write_value;
      logic [15:0]                 random_a;
      logic [15:0]                 random_b;
      logic [NB_MAX-1:0]           nb_vld;
      logic [NB_MAX-1:0][6:0]      nb_row;
      logic [NB_MAX-1:0][6:0]      nb_col;
   } entry_type;

   typedef struct packed {
      logic       read_value;
      logic [3:0] free_count;
      logic       divided;
      logic [5:0] first_row;
      logic [5:0] first_col;
      logic [5:0] second_row;
      logic [5:0] second_col;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR   = 4'd0,
      ST_IDLE    = 4'd1,
      ST_EXEC    = 4'd2,
      ST_READ    = 4'd3,
      ST_SCAN    = 4'd4,
      ST_EVAL    = 4'd5,
      ST_MOD     = 4'd6,
      ST_WR_SELF = 4'd7,
      ST_WR_A    = 4'd8,
      ST_WR_B    = 4'd9,
      ST_DONE    = 4'd10
   } state_type;

endpackage
`default_nettype wire

// File: hdl/gcds_front.sv
// Front end: classifies an incoming command and builds its in-bounds neighbour list.
// Depends on gcds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcds_front #(
   parameter int ROWS = gcds_pkg::ROWS_DEF,
   parameter int COLS = gcds_pkg::COLS_DEF
) (
   input  wire logic [1:0]         req_command,
   input  wire logic [5:0]         req_cell_row,
   input  wire logic [5:0]         req_cell_col,
   input  wire logic               req_write_value,
   input  wire logic [15:0]        req_random_a,
   input  wire logic [15:0]        req_random_b,
   output gcds_pkg::entry_type     entry
);

   // site class and neighbour slots
   always_comb begin
      int                r;
      int                c;
      int                nr;
      int                nc;
      gcds_pkg::loc_type loc;
      gcds_pkg::dir_type d;
      r = int'(req_cell_row);
      c = int'(req_cell_col);
      if (r == 0) begin
         loc = (c == 0) ? gcds_pkg::LOC_TL :
               (c == COLS - 1) ? gcds_pkg::LOC_TR : gcds_pkg::LOC_TOP;
      end else if (r == ROWS - 1) begin
         loc = (c == 0) ? gcds_pkg::LOC_BL :
               (c == COLS - 1) ? gcds_pkg::LOC_BR : gcds_pkg::LOC_BOTTOM;
      end else begin
         loc = (c == 0) ? gcds_pkg::LOC_LEFT :
               (c == COLS - 1) ? gcds_pkg::LOC_RIGHT : gcds_pkg::LOC_INNER;
      end
      entry.cmd         = gcds_pkg::cmd_type'(req_command);
      entry.in_grid     = (r < ROWS) && (c < COLS);
      entry.row         = req_cell_row;
      entry.col         = req_cell_col;
      entry.write_value = req_write_value;
      entry.random_a    = req_random_a;
      entry.random_b    = req_random_b;
      for (int i = 0; i < gcds_pkg::NB_MAX; i++) begin
         d  = gcds_pkg::NB_LIST[int'(loc)][i];
         nr = r + gcds_pkg::drow(d);
         nc = c + gcds_pkg::dcol(d);
         entry.nb_vld[i] = (4'(i) < gcds_pkg::NB_LEN[int'(loc)]) && (nr >= 0) && (nc >= 0)
                           && (nr < ROWS) && (nc < COLS);
         entry.nb_row[i] = 7'(nr);
         entry.nb_col[i] = 7'(nc);
      end
   end

endmodule
`default_nettype wire

// File: hdl/gcds_fifo.sv
// Two-entry queue of classified commands between front and back.
// Depends on gcds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcds_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  gcds_pkg::entry_type      din,
   output logic                     full,
   input  wire logic                pop,
   output gcds_pkg::entry_type      dout,
   output logic                     nempty
);

   gcds_pkg::entry_type mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full   = cnt_ff[1];
   assign nempty = (cnt_ff != 2'd0);
   assign dout   = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

// File: hdl/gcds_back.sv
// Back end: owns the occupancy memory, runs each queued command and holds the result beat.
// Depends on gcds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcds_back #(
   parameter int ROWS = gcds_pkg::ROWS_DEF,
   parameter int COLS = gcds_pkg::COLS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  gcds_pkg::entry_type      head,
   input  wire logic                head_vld,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output gcds_pkg::result_type     rsp
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);

   gcds_pkg::state_type  state_ff, state_in;
   gcds_pkg::entry_type  ent_ff, ent_in;
   gcds_pkg::result_type res_ff, res_in;
   gcds_pkg::result_type out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [3:0]           idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [6:0]           prow_ff, prow_in;
   logic [6:0]           pcol_ff, pcol_in;
   logic [6:0]           fr_ff [8];
   logic [6:0]           fr_in [8];
   logic [6:0]           fc_ff [8];
   logic [6:0]           fc_in [8];
   logic [3:0]           cnt_ff, cnt_in;
   logic [2:0]           rema_ff, rema_in;
   logic [2:0]           remb_ff, remb_in;
   logic [15:0]          sha_ff, sha_in;
   logic [15:0]          shb_ff, shb_in;
   logic [1:0]           step_ff, step_in;
   logic [2:0]           bsel_ff, bsel_in;

   logic                 mem_we;
   logic                 mem_wd;
   logic [AW-1:0]        mem_addr;
   logic                 mem_rd_ff;
   logic                 mem [DEPTH];

   function automatic logic [AW-1:0] site_addr(logic [6:0] r, logic [6:0] c);
      site_addr = AW'(int'(r) * COLS + int'(c));
   endfunction

   // one 4-bit slice of a restoring remainder, divisor 1..8
   function automatic logic [2:0] mod_slice(logic [2:0] rem, logic [3:0] bits,
                                             logic [3:0] dv);
      logic [3:0] t;
      logic [2:0] r;
      r = rem;
      for (int k = 3; k >= 0; k--) begin
         t = {r, bits[k]};
         if (t >= dv) begin
            t = t - dv;
         end
         r = t[2:0];
      end
      mod_slice = r;
   endfunction

   assign clearing  = (state_ff == gcds_pkg::ST_CLEAR);
   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

   // sequencer
   always_comb begin
      logic [3:0] dv_b;
      state_in   = state_ff;
      ent_in     = ent_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      prow_in    = prow_ff;
      pcol_in    = pcol_ff;
      fr_in      = fr_ff;
      fc_in      = fc_ff;
      cnt_in     = cnt_ff;
      rema_in    = rema_ff;
      remb_in    = remb_ff;
      sha_in     = sha_ff;
      shb_in     = shb_ff;
      step_in    = step_ff;
      bsel_in    = bsel_ff;
      pop        = 1'b0;
      mem_we     = 1'b0;
      mem_wd     = 1'b0;
      mem_addr   = site_addr({1'b0, ent_ff.row}, {1'b0, ent_ff.col});
      dv_b       = cnt_ff - 4'd1;
      case (state_ff)
         gcds_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = gcds_pkg::ST_IDLE;
            end
         end
         gcds_pkg::ST_IDLE: begin
            if (head_vld) begin
               pop      = 1'b1;
               ent_in   = head;
               res_in   = '0;
               state_in = gcds_pkg::ST_EXEC;
            end
         end
         gcds_pkg::ST_EXEC: begin
            state_in = gcds_pkg::ST_DONE;
            case (ent_ff.cmd)
               gcds_pkg::CMD_WRITE: begin
                  mem_we = ent_ff.in_grid;
                  mem_wd = ent_ff.write_value;
               end
               gcds_pkg::CMD_READ: begin
                  state_in = gcds_pkg::ST_READ;
               end
               gcds_pkg::CMD_DIVIDE: begin
                  if (ent_ff.in_grid) begin
                     idx_in   = 4'd0;
                     pend_in  = 1'b0;
                     cnt_in   = 4'd0;
                     state_in = gcds_pkg::ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         gcds_pkg::ST_READ: begin
            res_in.read_value = ent_ff.in_grid & mem_rd_ff;
            state_in          = gcds_pkg::ST_DONE;
         end
         gcds_pkg::ST_SCAN: begin
            // collect the reply of the previous read, issue the next slot
            if (pend_ff && !mem_rd_ff) begin
               fr_in[cnt_ff[2:0]] = prow_ff;
               fc_in[cnt_ff[2:0]] = pcol_ff;
               cnt_in             = cnt_ff + 4'd1;
            end
            if (idx_ff[3]) begin
               pend_in  = 1'b0;
               state_in = gcds_pkg::ST_EVAL;
            end else begin
               mem_addr = site_addr(ent_ff.nb_row[idx_ff[2:0]], ent_ff.nb_col[idx_ff[2:0]]);
               pend_in  = ent_ff.nb_vld[idx_ff[2:0]];
               prow_in  = ent_ff.nb_row[idx_ff[2:0]];
               pcol_in  = ent_ff.nb_col[idx_ff[2:0]];
               idx_in   = idx_ff + 4'd1;
            end
         end
         gcds_pkg::ST_EVAL: begin
            res_in.free_count = cnt_ff;
            rema_in           = 3'd0;
            remb_in           = 3'd0;
            sha_in            = ent_ff.random_a;
            shb_in            = ent_ff.random_b;
            step_in           = 2'd0;
            state_in          = (cnt_ff >= 4'd2) ? gcds_pkg::ST_MOD : gcds_pkg::ST_DONE;
         end
         gcds_pkg::ST_MOD: begin
            rema_in = mod_slice(rema_ff, sha_ff[15:12], cnt_ff);
            remb_in = mod_slice(remb_ff, shb_ff[15:12], dv_b);
            sha_in  = {sha_ff[11:0], 4'd0};
            shb_in  = {shb_ff[11:0], 4'd0};
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = gcds_pkg::ST_WR_SELF;
            end
         end
         gcds_pkg::ST_WR_SELF: begin
            mem_we   = 1'b1;
            bsel_in  = (remb_ff >= rema_ff) ? remb_ff + 3'd1 : remb_ff;
            state_in = gcds_pkg::ST_WR_A;
         end
         gcds_pkg::ST_WR_A: begin
            mem_we   = 1'b1;
            mem_wd   = 1'b1;
            mem_addr = site_addr(fr_ff[rema_ff], fc_ff[rema_ff]);
            state_in = gcds_pkg::ST_WR_B;
         end
         gcds_pkg::ST_WR_B: begin
            mem_we            = 1'b1;
            mem_wd            = 1'b1;
            mem_addr          = site_addr(fr_ff[bsel_ff], fc_ff[bsel_ff]);
            res_in.divided    = 1'b1;
            res_in.first_row  = fr_ff[rema_ff][5:0];
            res_in.first_col  = fc_ff[rema_ff][5:0];
            res_in.second_row = fr_ff[bsel_ff][5:0];
            res_in.second_col = fc_ff[bsel_ff][5:0];
            state_in          = gcds_pkg::ST_DONE;
         end
         gcds_pkg::ST_DONE: begin
            // hand the beat to the output register once it is free
            if (!out_vld_ff || !rsp_stall) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = gcds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gcds_pkg::ST_CLEAR;
         clr_ff     <= '0;
         out_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         out_vld_ff <= out_vld_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      idx_ff  <= idx_in;
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      fr_ff   <= fr_in;
      fc_ff   <= fc_in;
      cnt_ff  <= cnt_in;
      rema_ff <= rema_in;
      remb_ff <= remb_in;
      sha_ff  <= sha_in;
      shb_ff  <= shb_in;
      step_ff <= step_in;
      bsel_ff <= bsel_in;
   end

   // single-port occupancy memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_addr];
   end

endmodule
`default_nettype wire

// File: hdl/grid_cell_division_step.sv
// Occupancy grid with cell division: top level joining front, queue and back.
// Depends on gcds_pkg, gcds_front, gcds_fifo and gcds_back.
//
// Usage: commands arrive as beats on the req_ channel (valid/stall): write a
// site, read a site, or divide the cell at a site. Every accepted beat yields
// exactly one result beat on the rsp_ channel, in order.
// Flow through the back end: a write, an unknown command or an out-of-grid
// divide goes from execute straight to the result; a read adds a memory read;
// a divide reads its neighbour slots, and with at least two free neighbours
// runs four remainder slices and three memory writes.
// Throughput is set by the single-port occupancy memory: one command at a
// time in the back end. A two-entry queue lets the front keep taking beats
// while the back end works.
// After reset a clearing pass writes every site to empty, one site a cycle;
// req_stall stays high until it ends.
// When the receiver stalls, the result beat holds in the output register;
// the back end finishes the next command and waits, and the queue then fills.
`timescale 1ns / 1ps
`default_nettype none
module grid_cell_division_step #(
   parameter int ROWS = gcds_pkg::ROWS_DEF,
   parameter int COLS = gcds_pkg::COLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [5:0]  req_cell_row,
   input  wire logic [5:0]  req_cell_col,
   input  wire logic        req_write_value,
   input  wire logic [15:0] req_random_a,
   input  wire logic [15:0] req_random_b,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_read_value,
   output logic [3:0]       rsp_free_count,
   output logic             rsp_divided,
   output logic [5:0]       rsp_first_row,
   output logic [5:0]       rsp_first_col,
   output logic [5:0]       rsp_second_row,
   output logic [5:0]       rsp_second_col
);

   gcds_pkg::entry_type  fe_entry;
   gcds_pkg::entry_type  head;
   gcds_pkg::result_type res;
   logic                 q_full;
   logic                 q_nempty;
   logic                 q_pop;
   logic                 clearing;
   logic                 push;

   assign req_stall = q_full | clearing;
   assign push      = req_valid & ~req_stall;

   gcds_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
      .req_command     (req_command),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_write_value (req_write_value),
      .req_random_a    (req_random_a),
      .req_random_b    (req_random_b),
      .entry           (fe_entry)
   );

   gcds_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (fe_entry),
      .full   (q_full),
      .pop    (q_pop),
      .dout   (head),
      .nempty (q_nempty)
   );

   gcds_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_vld  (q_nempty),
      .pop       (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (res)
   );

   assign rsp_read_value = res.read_value;
   assign rsp_free_count = res.free_count;
   assign rsp_divided    = res.divided;
   assign rsp_first_row  = res.first_row;
   assign rsp_first_col  = res.first_col;
   assign rsp_second_row = res.second_row;
   assign rsp_second_col = res.second_col;

endmodule
`default_nettype wire
